/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_SYNC(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// checked on every clock edge, reset included
`define ASSERT_ANY(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

/* rtl/ses_pkg.sv */
package ses_pkg;

   // width of the section offset counter, positions saturate at its maximum
   localparam int POSITION_WIDTH = 16;
   localparam int STOP_POS_WIDTH = 16;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

   // scanner states
   localparam logic [3:0] ST_CODE       = 4'd0;
   localparam logic [3:0] ST_LT         = 4'd1;
   localparam logic [3:0] ST_SLASH      = 4'd2;
   localparam logic [3:0] ST_LINE       = 4'd3;
   localparam logic [3:0] ST_LINE_LT    = 4'd4;
   localparam logic [3:0] ST_BLOCK      = 4'd5;
   localparam logic [3:0] ST_BLOCK_STAR = 4'd6;
   localparam logic [3:0] ST_REGEX      = 4'd7;
   localparam logic [3:0] ST_REGEX_ESC  = 4'd8;
   localparam logic [3:0] ST_DQ         = 4'd9;
   localparam logic [3:0] ST_DQ_ESC     = 4'd10;
   localparam logic [3:0] ST_SQ         = 4'd11;
   localparam logic [3:0] ST_SQ_ESC     = 4'd12;
   localparam logic [3:0] ST_BAD        = 4'd15;

   // stop reasons
   localparam logic [1:0] RSN_TAG        = 2'd0;
   localparam logic [1:0] RSN_UNEXPECTED = 2'd1;
   localparam logic [1:0] RSN_END        = 2'd2;

   // special bytes
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_LT     = 8'h3C;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;

   typedef struct packed {
      logic [3:0] code_next;
      logic       is_slash;
      logic       is_lt;
      logic       is_star;
      logic       is_bslash;
      logic       is_lf;
      logic       is_dq;
      logic       is_sq;
   } byte_class_type;

   typedef struct packed {
      logic                      found;
      logic [POSITION_WIDTH-1:0] position;
      logic [1:0]                reason;
   } scan_result_type;

endpackage

/* rtl/ses_byte_class.sv */
module ses_byte_class (
   input  logic [7:0]              data_byte,
   output ses_pkg::byte_class_type byte_class
);

   always_comb begin
      byte_class.is_slash  = (data_byte == ses_pkg::CHR_SLASH);
      byte_class.is_lt     = (data_byte == ses_pkg::CHR_LT);
      byte_class.is_star   = (data_byte == ses_pkg::CHR_STAR);
      byte_class.is_bslash = (data_byte == ses_pkg::CHR_BSLASH);
      byte_class.is_lf     = (data_byte == ses_pkg::CHR_LF);
      byte_class.is_dq     = (data_byte == ses_pkg::CHR_DQUOTE);
      byte_class.is_sq     = (data_byte == ses_pkg::CHR_SQUOTE);

      // next state when the byte is seen as code
      case (data_byte) inside
         ses_pkg::CHR_SLASH:  byte_class.code_next = ses_pkg::ST_SLASH;
         ses_pkg::CHR_LT:     byte_class.code_next = ses_pkg::ST_LT;
         ses_pkg::CHR_DQUOTE: byte_class.code_next = ses_pkg::ST_DQ;
         ses_pkg::CHR_SQUOTE: byte_class.code_next = ses_pkg::ST_SQ;
         // whitespace
         8'h20, [8'h09:8'h0D],
         // letters, digits, underscore
         [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F,
         // punctuation allowed in code
         8'h3A, 8'h3B, 8'h2E, 8'h2C, 8'h28, 8'h29, 8'h5B, 8'h5D,
         8'h7B, 8'h7D, 8'h21, 8'h3F, 8'h3D, 8'h2B, 8'h2D, 8'h2A,
         8'h25, 8'h5E, 8'h26, 8'h7C, 8'h7E, 8'h3E, 8'h24:
            byte_class.code_next = ses_pkg::ST_CODE;
         default: byte_class.code_next = ses_pkg::ST_BAD;
      endcase
   end

endmodule

/* rtl/ses_scan_core.sv */
module ses_scan_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     first_byte,
   input  logic                     last_byte,
   input  ses_pkg::byte_class_type  byte_class,
   output ses_pkg::scan_result_type result
);

   logic [3:0]                         state_ff;
   logic [3:0]                         state_in;
   logic [ses_pkg::POSITION_WIDTH-1:0] offset_ff;
   logic [ses_pkg::POSITION_WIDTH-1:0] offset_in;
   logic                               finished_ff;
   logic                               finished_in;

   logic [3:0]                         cur_state;
   logic [ses_pkg::POSITION_WIDTH-1:0] idx;
   logic [ses_pkg::POSITION_WIDTH-1:0] nxt;
   logic [ses_pkg::POSITION_WIDTH-1:0] tag_pos;
   logic                               cur_finished;
   logic                               tag_hit;
   logic [3:0]                         ns;

   always_comb begin
      // a section start drops everything before the byte is scanned
      cur_state    = first_byte ? ses_pkg::ST_CODE : state_ff;
      idx          = first_byte ? '0 : offset_ff;
      cur_finished = first_byte ? 1'b0 : finished_ff;

      nxt     = (idx == ses_pkg::POS_MAX) ? ses_pkg::POS_MAX : idx + 1'b1;
      tag_pos = (idx == '0) ? '0 : idx - 1'b1;
      tag_hit = 1'b0;

      case (cur_state)
         ses_pkg::ST_LT: begin
            if (byte_class.is_slash) begin
               tag_hit = 1'b1;
               ns      = ses_pkg::ST_CODE;
            end else begin
               ns = byte_class.code_next;
            end
         end
         ses_pkg::ST_SLASH: begin
            if (byte_class.is_slash)       ns = ses_pkg::ST_LINE;
            else if (byte_class.is_star)   ns = ses_pkg::ST_BLOCK;
            else if (byte_class.is_bslash) ns = ses_pkg::ST_REGEX_ESC;
            else                           ns = ses_pkg::ST_REGEX;
         end
         ses_pkg::ST_LINE, ses_pkg::ST_LINE_LT: begin
            if (cur_state == ses_pkg::ST_LINE_LT && byte_class.is_slash) begin
               tag_hit = 1'b1;
               ns      = ses_pkg::ST_CODE;
            end else if (byte_class.is_lf) begin
               ns = ses_pkg::ST_CODE;
            end else if (byte_class.is_lt) begin
               ns = ses_pkg::ST_LINE_LT;
            end else begin
               ns = ses_pkg::ST_LINE;
            end
         end
         ses_pkg::ST_BLOCK: begin
            ns = byte_class.is_star ? ses_pkg::ST_BLOCK_STAR : ses_pkg::ST_BLOCK;
         end
         ses_pkg::ST_BLOCK_STAR: begin
            if (byte_class.is_slash)     ns = ses_pkg::ST_CODE;
            else if (byte_class.is_star) ns = ses_pkg::ST_BLOCK_STAR;
            else                         ns = ses_pkg::ST_BLOCK;
         end
         ses_pkg::ST_REGEX: begin
            if (byte_class.is_slash)       ns = ses_pkg::ST_CODE;
            else if (byte_class.is_bslash) ns = ses_pkg::ST_REGEX_ESC;
            else                           ns = ses_pkg::ST_REGEX;
         end
         ses_pkg::ST_REGEX_ESC: ns = ses_pkg::ST_REGEX;
         ses_pkg::ST_DQ: begin
            if (byte_class.is_dq)          ns = ses_pkg::ST_CODE;
            else if (byte_class.is_bslash) ns = ses_pkg::ST_DQ_ESC;
            else                           ns = ses_pkg::ST_DQ;
         end
         ses_pkg::ST_DQ_ESC: ns = ses_pkg::ST_DQ;
         ses_pkg::ST_SQ: begin
            if (byte_class.is_sq)          ns = ses_pkg::ST_CODE;
            else if (byte_class.is_bslash) ns = ses_pkg::ST_SQ_ESC;
            else                           ns = ses_pkg::ST_SQ;
         end
         ses_pkg::ST_SQ_ESC: ns = ses_pkg::ST_SQ;
         default: ns = byte_class.code_next;
      endcase

      result.found    = 1'b0;
      result.position = nxt;
      result.reason   = ses_pkg::RSN_END;
      if (tag_hit) begin
         result.found    = 1'b1;
         result.position = tag_pos;
         result.reason   = ses_pkg::RSN_TAG;
      end else if (ns == ses_pkg::ST_BAD) begin
         result.found  = 1'b1;
         result.reason = ses_pkg::RSN_UNEXPECTED;
         ns            = ses_pkg::ST_CODE;
      end else if (last_byte) begin
         result.found = 1'b1;
      end

      // once finished, bytes are dropped until a section start
      if (cur_finished) result.found = 1'b0;

      state_in    = state_ff;
      offset_in   = offset_ff;
      finished_in = finished_ff;
      if (step_en) begin
         if (cur_finished) begin
            state_in    = cur_state;
            offset_in   = idx;
            finished_in = cur_finished;
         end else begin
            state_in    = ns;
            offset_in   = nxt;
            finished_in = result.found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ses_pkg::ST_CODE;
         offset_ff   <= '0;
         finished_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         offset_ff   <= offset_in;
         finished_ff <= finished_in;
      end
   end

endmodule

/* rtl/script_end_scanner.sv */
// channel  dir  tdata                   tuser              tlast
// req      in   [7:0] data_byte         [0] first_byte     last_byte
// rsp      out  [15:0] stop_position    [1:0] stop_reason  -
//
// one word a cycle in and out when the result side is not stalled
// a word is registered in the input register, scanned from there when the
// result register can take its answer, and its result, if any, lands there
// the scan state, offset and finished flag update once per scanned word
// reset clears the scanner to code state at offset zero and empties both
// registers; a stalled result holds the input register and so req_tready
module script_end_scanner (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] stop_position
   output logic [1:0]  rsp_tuser    // [1:0] stop_reason
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_first_ff;
   logic       in_last_ff;

   // result register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [15:0] out_pos_ff;
   logic [1:0]  out_reason_ff;

   logic                     advance;
   logic                     req_take;
   ses_pkg::byte_class_type  byte_class;
   ses_pkg::scan_result_type result;

   // the held word is scanned when the result register can take its answer
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)         out_valid_in = result.found;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_last_ff  <= req_tlast;
      end
      if (advance && result.found) begin
         out_pos_ff    <= ses_pkg::STOP_POS_WIDTH'(result.position);
         out_reason_ff <= result.reason;
      end
   end

   ses_byte_class u_byte_class (
      .data_byte  (in_data_ff),
      .byte_class (byte_class)
   );

   ses_scan_core u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .first_byte (in_first_ff),
      .last_byte  (in_last_ff),
      .byte_class (byte_class),
      .result     (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pos_ff;
   assign rsp_tuser  = out_reason_ff;

endmodule

/* rtl/ses_checker.sv */
`include "assert_macros.svh"

module ses_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // nothing leaves the block in the cycle after reset
   `ASSERT_ANY(a_no_rsp_after_reset, $past(reset) |-> !rsp_tvalid)

   // a stalled result keeps its value
   `ASSERT_SYNC(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // with the result register empty the input side never stalls
   `ASSERT_SYNC(a_req_flows, !rsp_tvalid |-> req_tready)

   // an unused reason code never shows, and req_tvalid is not X while a result is valid
   `ASSERT_SYNC(a_reason_code, rsp_tvalid |-> rsp_tuser != 2'd3 && !(req_tvalid === 1'bx))

endmodule

bind script_end_scanner ses_checker u_ses_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import ses_pkg::*;

   localparam int QUIET_LIMIT = 3000;   // cycles with no word moving on either side
   localparam int HOLD_CYCLES = 300;    // long result-side hold

   typedef struct packed {
      logic [STOP_POS_WIDTH-1:0] pos;
      logic [1:0]                why;
   } stop_word_type;

   typedef struct {
      logic [7:0] data;
      bit         is_first;
      bit         is_last;
      bit         typed;      // result written out by hand on this row
      logic [15:0] pos;
      logic [1:0]  why;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [0:0]  req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // local copy of the scanner state, at its after-reset values
   logic [3:0]                scan_mode  = ST_CODE;
   logic [POSITION_WIDTH-1:0] sec_offset = '0;
   bit                        sec_closed = 1'b0;

   stop_word_type stops_due [$];
   int         mismatches    = 0;
   int         bytes_scanned = 0;
   int         quiet_cycles  = 0;
   int         send_gap_pct  = 36;
   int         recv_gap_pct  = 45;
   logic       rsp_hold      = 1'b0;
   event       hold_results;

   dir_row_type directed_rows [25] = '{
      '{8'h00,      1'b0, 1'b0, 1'b1, 16'd1, RSN_UNEXPECTED}, // zero byte right after reset
      '{8'hFF,      1'b1, 1'b1, 1'b1, 16'd1, RSN_UNEXPECTED}, // high byte that is also last
      '{CHR_LT,     1'b1, 1'b1, 1'b1, 16'd1, RSN_END},        // tag split by the last byte
      '{"a",        1'b1, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_LT,     1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_SLASH,  1'b0, 1'b0, 1'b1, 16'd1, RSN_TAG},        // closing tag, index of '<'
      '{"x",        1'b0, 1'b1, 1'b0, 16'd0, RSN_TAG},        // ignored once finished
      '{CHR_SLASH,  1'b1, 1'b0, 1'b0, 16'd0, RSN_TAG},        // line comment
      '{CHR_SLASH,  1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_LT,     1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_LF,     1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},        // newline drops the pending '<'
      '{CHR_SLASH,  1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},        // block comment closed by **/
      '{CHR_STAR,   1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_STAR,   1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_STAR,   1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_SLASH,  1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_DQUOTE, 1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},        // string with an escaped quote
      '{CHR_BSLASH, 1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_DQUOTE, 1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_DQUOTE, 1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_SLASH,  1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},        // division sign opens a regex
      '{"q",        1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_SLASH,  1'b0, 1'b0, 1'b0, 16'd0, RSN_TAG},
      '{CHR_SQUOTE, 1'b0, 1'b1, 1'b0, 16'd0, RSN_TAG},        // string still open at last
      '{":",        1'b1, 1'b1, 1'b1, 16'd1, RSN_END}
   };

   script_end_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // where a byte seen as code leads, ST_BAD when code may not hold it
   function automatic logic [3:0] code_class(logic [7:0] b);
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) return ST_CODE;
      if (b == CHR_SLASH)  return ST_SLASH;
      if (b == CHR_LT)     return ST_LT;
      if (b == CHR_DQUOTE) return ST_DQ;
      if (b == CHR_SQUOTE) return ST_SQ;
      if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
          (b >= "0" && b <= "9") || b == "_") return ST_CODE;
      case (b)
         ":", ";", ".", ",", "(", ")", "[", "]", "{", "}", "!", "?",
         "=", "+", "-", "*", "%", "^", "&", "|", "~", ">", "$": return ST_CODE;
         default: return ST_BAD;
      endcase
   endfunction

   // scans one byte; returns 1 with the stop word when the scan ends here
   function automatic bit predict_stop(input logic [7:0] b, input bit is_first,
                                       input bit is_last, output stop_word_type res,
                                       output bit skipped);
      logic [POSITION_WIDTH-1:0] idx, nxt, at;
      logic [3:0] nx;
      bit hit;
      hit = 1'b0;
      res = '0;
      at = '0;
      nx = ST_CODE;
      skipped = 1'b0;
      if (is_first) begin
         scan_mode  = ST_CODE;
         sec_offset = '0;
         sec_closed = 1'b0;
      end
      if (sec_closed) begin
         skipped = 1'b1;
         return 1'b0;
      end
      idx = sec_offset;
      nxt = (idx == POS_MAX) ? idx : idx + 1'b1;
      sec_offset = nxt;
      case (scan_mode)
         ST_LT: begin
            if (b == CHR_SLASH) begin
               hit = 1'b1;
               res.why = RSN_TAG;
               at = (idx != 0) ? idx - 1'b1 : '0;
            end else begin
               nx = code_class(b);
            end
         end
         ST_SLASH: begin
            if (b == CHR_SLASH)       nx = ST_LINE;
            else if (b == CHR_STAR)   nx = ST_BLOCK;
            else if (b == CHR_BSLASH) nx = ST_REGEX_ESC;
            else                      nx = ST_REGEX;
         end
         ST_LINE, ST_LINE_LT: begin
            if (scan_mode == ST_LINE_LT && b == CHR_SLASH) begin
               hit = 1'b1;
               res.why = RSN_TAG;
               at = (idx != 0) ? idx - 1'b1 : '0;
            end else if (b == CHR_LF) nx = ST_CODE;
            else if (b == CHR_LT)     nx = ST_LINE_LT;
            else                      nx = ST_LINE;
         end
         ST_BLOCK: nx = (b == CHR_STAR) ? ST_BLOCK_STAR : ST_BLOCK;
         ST_BLOCK_STAR: begin
            if (b == CHR_SLASH)     nx = ST_CODE;
            else if (b == CHR_STAR) nx = ST_BLOCK_STAR;
            else                    nx = ST_BLOCK;
         end
         ST_REGEX: begin
            if (b == CHR_SLASH)       nx = ST_CODE;
            else if (b == CHR_BSLASH) nx = ST_REGEX_ESC;
            else                      nx = ST_REGEX;
         end
         ST_REGEX_ESC: nx = ST_REGEX;
         ST_DQ: begin
            if (b == CHR_DQUOTE)      nx = ST_CODE;
            else if (b == CHR_BSLASH) nx = ST_DQ_ESC;
            else                      nx = ST_DQ;
         end
         ST_DQ_ESC: nx = ST_DQ;
         ST_SQ: begin
            if (b == CHR_SQUOTE)      nx = ST_CODE;
            else if (b == CHR_BSLASH) nx = ST_SQ_ESC;
            else                      nx = ST_SQ;
         end
         ST_SQ_ESC: nx = ST_SQ;
         default: nx = code_class(b);
      endcase
      if (!hit && nx == ST_BAD) begin
         hit = 1'b1;
         res.why = RSN_UNEXPECTED;
         at = nxt;
         nx = ST_CODE;
      end
      scan_mode = nx;
      if (!hit && is_last) begin
         hit = 1'b1;
         res.why = RSN_END;
         at = nxt;
      end
      res.pos = at[STOP_POS_WIDTH-1:0];
      if (hit) sec_closed = 1'b1;
      return hit;
   endfunction

   function automatic logic [7:0] any_but(logic [7:0] x, logic [7:0] y);
      logic [7:0] v;
      do v = 8'($urandom_range(255)); while (v == x || v == y);
      return v;
   endfunction

   function automatic logic [7:0] word_char();
      int v;
      v = $urandom_range(62);
      if (v < 26) return "a" + 8'(v);
      if (v < 52) return "A" + 8'(v - 26);
      if (v < 62) return "0" + 8'(v - 52);
      return "_";
   endfunction

   function automatic logic [7:0] blank_char();
      int v;
      v = $urandom_range(5);
      return (v == 5) ? " " : 8'(9 + v);
   endfunction

   // one body byte of a string or regex, sometimes an escape pair
   task automatic quoted_byte(ref logic [7:0] txt [$], input logic [7:0] term);
      if ($urandom_range(4) == 0) begin
         txt.push_back(CHR_BSLASH);
         txt.push_back(8'($urandom_range(255)));
      end else begin
         txt.push_back(any_but(term, CHR_BSLASH));
      end
   endtask

   // offers one word, waits for it to be taken, then books its prediction
   task automatic push_word(input logic [7:0] b, input bit is_first, input bit is_last,
                            input bit typed = 1'b0, input stop_word_type typed_stop = '0);
      stop_word_type want;
      bit hit, skipped;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= is_first;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      hit = predict_stop(b, is_first, is_last, want, skipped);
      if (typed)    stops_due.push_back(typed_stop);
      else if (hit) stops_due.push_back(want);
      if (!skipped) bytes_scanned++;
   endtask

   // sender stops and waits for every booked result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (stops_due.size() != 0) @(posedge clock);
   endtask

   // a section of random tokens, strings, comments and regexes, closed in one of several ways
   task automatic random_section();
      logic [7:0] txt [$];
      logic [7:0] b;
      int ntok, tk;
      bit lead, tail_last;
      ntok = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      repeat (ntok) begin
         tk = $urandom_range(9);
         case (tk)
            0, 1: repeat ($urandom_range(1, 6)) txt.push_back(word_char());
            2: txt.push_back(blank_char());
            3: begin
               do b = 8'($urandom_range(33, 126)); while (code_class(b) != ST_CODE);
               txt.push_back(b);
            end
            4, 5: begin
               b = (tk == 4) ? CHR_DQUOTE : CHR_SQUOTE;
               txt.push_back(b);
               repeat ($urandom_range(0, 8)) quoted_byte(txt, b);
               txt.push_back(b);
            end
            6: begin
               txt.push_back(CHR_SLASH);
               txt.push_back(CHR_SLASH);
               repeat ($urandom_range(0, 10)) txt.push_back(any_but(CHR_LF, CHR_LF));
               txt.push_back(CHR_LF);
            end
            7: begin
               txt.push_back(CHR_SLASH);
               txt.push_back(CHR_STAR);
               repeat ($urandom_range(0, 10)) begin
                  if ($urandom_range(4) == 0) begin
                     // lone star that must not close the comment
                     txt.push_back(CHR_STAR);
                     txt.push_back(any_but(CHR_SLASH, CHR_STAR));
                  end else begin
                     txt.push_back(any_but(CHR_STAR, CHR_STAR));
                  end
               end
               if ($urandom_range(1)) txt.push_back(CHR_STAR);
               txt.push_back(CHR_STAR);
               txt.push_back(CHR_SLASH);
            end
            8: begin
               txt.push_back(CHR_SLASH);
               txt.push_back(any_but(CHR_SLASH, CHR_STAR));
               repeat ($urandom_range(0, 6)) quoted_byte(txt, CHR_SLASH);
               txt.push_back(CHR_SLASH);
            end
            default: begin
               txt.push_back(CHR_LT);
               txt.push_back(word_char());
            end
         endcase
      end
      tail_last = 1'b0;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            txt.push_back(CHR_LT);
            txt.push_back(CHR_SLASH);
            tail_last = ($urandom_range(3) == 0);
         end
         4, 5: begin
            do b = 8'($urandom_range(255)); while (code_class(b) != ST_BAD);
            txt.push_back(b);
            tail_last = 1'($urandom_range(1));
         end
         6, 7: begin
            // leave something open when the last byte comes
            case ($urandom_range(5))
               0: txt.push_back(CHR_LT);
               1: txt.push_back(CHR_SLASH);
               2: txt.push_back(CHR_DQUOTE);
               3: begin
                  txt.push_back(CHR_SQUOTE);
                  txt.push_back(CHR_BSLASH);
               end
               4: begin
                  txt.push_back(CHR_SLASH);
                  txt.push_back(CHR_SLASH);
               end
               default: begin
                  txt.push_back(CHR_SLASH);
                  txt.push_back(CHR_STAR);
               end
            endcase
            tail_last = 1'b1;
         end
         default: begin
            repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(255)));
            tail_last = 1'($urandom_range(1));
         end
      endcase
      lead = ($urandom_range(15) != 0);
      foreach (txt[i])
         push_word(txt[i], lead && (i == 0),
                   (i == txt.size() - 1) ? tail_last : ($urandom_range(63) == 0));
      // a few words after the stop, normally ignored
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3))
            push_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
   endtask

   // result side: random stalls, or a long hold on request
   always @(posedge clock)
      rsp_tready <= rsp_hold ? 1'b0 : ($urandom_range(99) >= recv_gap_pct);

   always begin
      @(hold_results);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      stop_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (stops_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: position %0d reason %0d",
                        rsp_tdata, rsp_tuser);
         end else begin
            want = stops_due.pop_front();
            if (rsp_tdata !== want.pos || rsp_tuser !== want.why) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: position exp %0d got %0d, reason exp %0d got %0d",
                           want.pos, rsp_tdata, want.why, rsp_tuser);
            end
         end
      end
   end

   // watchdog on cycles where no word moves
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender idles less than the receiver
      send_gap_pct = 36;
      recv_gap_pct = 45;
      foreach (directed_rows[i])
         push_word(directed_rows[i].data, directed_rows[i].is_first,
                   directed_rows[i].is_last, directed_rows[i].typed,
                   '{directed_rows[i].pos, directed_rows[i].why});
      drain_results();
      -> hold_results;
      target = bytes_scanned + 500;
      while (bytes_scanned < target) random_section();
      drain_results();

      // the other way round
      send_gap_pct = 45;
      recv_gap_pct = 36;
      target = bytes_scanned + 500;
      while (bytes_scanned < target) random_section();
      drain_results();

      // no idling
      send_gap_pct = 0;
      recv_gap_pct = 0;
      target = bytes_scanned + 500;
      while (bytes_scanned < target) random_section();
      drain_results();

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
